[hw/rtl/tps_pkg.sv]
// Shared types and constants of the thin plate spline evaluator.
`timescale 1ns / 1ps

package tps_pkg;

  // Coordinate, weight and coefficient width (signed Q16.16).
  localparam int unsigned COORD_W = 32;
  // Height result width (signed Q32.16).
  localparam int unsigned HEIGHT_W = 48;
  // Width of one signed, clamped spline term in Q.16.
  localparam int unsigned TERM_W = 58;
  // Number of register stages in the term unit.
  localparam int unsigned PIPE_DEPTH = 11;
  // Width of the drain counter; it must hold PIPE_DEPTH - 1.
  localparam int unsigned DRAIN_W = 4;
  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AFF_C  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AFF_X  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AFF_Z  = 2'd3;

  // Operation codes of an input item.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // One control point as held in a cell.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] w;
  } point_t;

  // One finished term leaving the term unit.
  typedef struct packed {
    logic                     vld;
    logic signed [TERM_W-1:0] value;
    logic                     sat;
  } term_t;

endpackage

[hw/rtl/tps_cell.sv]
// One cell of the control point ring: holds a point, loads it or passes it on.
`timescale 1ns / 1ps

module tps_cell (
  input  logic            clk_i,
  input  logic            load_i,
  input  logic            shift_i,
  input  tps_pkg::point_t load_pt_i,
  input  tps_pkg::point_t next_pt_i,
  output tps_pkg::point_t pt_o
);

  tps_pkg::point_t pt_q, pt_d;

  // A load writes this cell; during an evaluation the ring turns by one.
  always_comb begin
    pt_d = pt_q;
    if (load_i) begin
      pt_d = load_pt_i;
    end else if (shift_i) begin
      pt_d = next_pt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q <= pt_d;
  end

  assign pt_o = pt_q;

endmodule

[hw/rtl/tps_term.sv]
// Pipelined term unit: weight times U(d2) for one control point per cycle.
`timescale 1ns / 1ps

module tps_term (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                issue_i,
  input  logic        [tps_pkg::COORD_W-1:0]  qx_i,
  input  logic        [tps_pkg::COORD_W-1:0]  qz_i,
  input  tps_pkg::point_t                     pt_i,
  output tps_pkg::term_t                      term_o
);

  localparam int unsigned LN_W  = 23;
  localparam int unsigned MAG_W = 21;
  localparam int unsigned MG_W  = 53;
  localparam logic signed [LN_W-1:0] LN2_Q16 = 23'sd45426;
  localparam logic [56:0] TERM_LIM = 57'h100_0000_0000_0000;

  // Table of round(65536 * ln(1 + k/16)).
  function automatic logic [15:0] ln_tab(input logic [4:0] k);
    logic [15:0] r;
    case (k)
      5'd0:  r = 16'd0;
      5'd1:  r = 16'd3973;
      5'd2:  r = 16'd7719;
      5'd3:  r = 16'd11262;
      5'd4:  r = 16'd14624;
      5'd5:  r = 16'd17821;
      5'd6:  r = 16'd20870;
      5'd7:  r = 16'd23783;
      5'd8:  r = 16'd26573;
      5'd9:  r = 16'd29248;
      5'd10: r = 16'd31818;
      5'd11: r = 16'd34292;
      5'd12: r = 16'd36675;
      5'd13: r = 16'd38975;
      5'd14: r = 16'd41196;
      5'd15: r = 16'd43345;
      5'd16: r = 16'd45426;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  // Position of the leading one of the squared distance.
  function automatic logic [6:0] lead_one(input logic [64:0] v);
    logic [6:0] r;
    r = '0;
    for (int i = 0; i < 65; i++) begin
      if (v[i]) begin
        r = 7'(i);
      end
    end
    return r;
  endfunction

  logic [tps_pkg::PIPE_DEPTH-1:0] vld_q;

  // Valid bits travel with the data through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[tps_pkg::PIPE_DEPTH-2:0], issue_i};
    end
  end

  // Stage 1: coordinate differences and their magnitudes.
  logic [32:0] dx, dz, ndx, ndz;
  logic [31:0] ax_q, az_q, w1_q;
  assign dx  = {qx_i[31], qx_i} - {pt_i.x[31], pt_i.x};
  assign dz  = {qz_i[31], qz_i} - {pt_i.z[31], pt_i.z};
  assign ndx = -dx;
  assign ndz = -dz;
  always_ff @(posedge clk_i) begin
    ax_q <= dx[32] ? ndx[31:0] : dx[31:0];
    az_q <= dz[32] ? ndz[31:0] : dz[31:0];
    w1_q <= pt_i.w;
  end

  // Stage 2: squares.
  logic [63:0] sqx_q, sqz_q;
  logic [31:0] w2_q;
  always_ff @(posedge clk_i) begin
    sqx_q <= {32'b0, ax_q} * {32'b0, ax_q};
    sqz_q <= {32'b0, az_q} * {32'b0, az_q};
    w2_q  <= w1_q;
  end

  // Stage 3: exact squared distance in Q.32.
  logic [64:0] s3_q;
  logic [31:0] w3_q;
  always_ff @(posedge clk_i) begin
    s3_q <= {1'b0, sqx_q} + {1'b0, sqz_q};
    w3_q <= w2_q;
  end

  // Stage 4: leading one search.
  logic [64:0] s4_q;
  logic [6:0]  p4_q;
  logic        nz4_q;
  logic [31:0] w4_q;
  always_ff @(posedge clk_i) begin
    s4_q  <= s3_q;
    p4_q  <= lead_one(s3_q);
    nz4_q <= |s3_q;
    w4_q  <= w3_q;
  end

  // Stage 5: normalize to a 32-bit mantissa with the leading one on top.
  logic [95:0] norm;
  logic [31:0] m5_q, w5_q;
  logic [6:0]  p5_q;
  logic        nz5_q;
  assign norm = {s4_q, 31'b0} >> p4_q;
  always_ff @(posedge clk_i) begin
    m5_q  <= norm[31:0];
    p5_q  <= p4_q;
    nz5_q <= nz4_q;
    w5_q  <= w4_q;
  end

  // Stage 6: table lookup with linear interpolation, and the exponent part.
  logic [4:0]            k6;
  logic [11:0]           t6;
  logic [15:0]           base6, diff6;
  logic [27:0]           ip6;
  logic signed [7:0]     pc6;
  logic [15:0]           lm6_q;
  logic signed [LN_W-1:0] pl6_q;
  logic [31:0]           m6_q, w6_q;
  logic [6:0]            p6_q;
  logic                  nz6_q;
  assign k6    = {1'b0, m5_q[30:27]};
  assign t6    = m5_q[26:15];
  assign base6 = ln_tab(k6);
  assign diff6 = ln_tab(k6 + 5'd1) - base6;
  assign ip6   = {12'b0, diff6} * {16'b0, t6};
  assign pc6   = $signed({1'b0, p5_q}) - 8'sd32;
  always_ff @(posedge clk_i) begin
    lm6_q <= base6 + ip6[27:12];
    pl6_q <= LN_W'(pc6) * LN2_Q16;
    m6_q  <= m5_q;
    p6_q  <= p5_q;
    nz6_q <= nz5_q;
    w6_q  <= w5_q;
  end

  // Stage 7: natural log in Q.16, split into sign and magnitude.
  logic signed [LN_W-1:0] ln7, nln7;
  logic [MAG_W-1:0]       lmag7_q;
  logic                   neg7_q, nz7_q;
  logic [31:0]            m7_q, w7_q;
  logic [6:0]             p7_q;
  assign ln7  = pl6_q + $signed({7'b0, lm6_q});
  assign nln7 = -ln7;
  always_ff @(posedge clk_i) begin
    lmag7_q <= ln7[LN_W-1] ? nln7[MAG_W-1:0] : ln7[MAG_W-1:0];
    neg7_q  <= ln7[LN_W-1];
    nz7_q   <= nz6_q;
    m7_q    <= m6_q;
    p7_q    <= p6_q;
    w7_q    <= w6_q;
  end

  // Stage 8: mantissa times log magnitude.
  logic [MG_W-1:0] mg8_q;
  logic [6:0]      p8_q;
  logic            neg8_q, nz8_q;
  logic [31:0]     w8_q;
  always_ff @(posedge clk_i) begin
    mg8_q  <= {21'b0, m7_q} * {32'b0, lmag7_q};
    p8_q   <= p7_q;
    neg8_q <= neg7_q;
    nz8_q  <= nz7_q;
    w8_q   <= w7_q;
  end

  // Stage 9: scale back by the leading one position to get U in Q.16.
  logic [6:0]      amt9;
  logic [MG_W-1:0] u9_q;
  logic            un9_q;
  logic [31:0]     w9_q;
  assign amt9 = 7'd64 - p8_q;
  always_ff @(posedge clk_i) begin
    u9_q  <= nz8_q ? (mg8_q >> amt9) : '0;
    un9_q <= nz8_q & neg8_q;
    w9_q  <= w8_q;
  end

  // Stage 10: U times the weight magnitude, as high and low partial products.
  logic [31:0]     nw10, aw10;
  logic [MG_W-1:0] hi10_q;
  logic [63:0]     lo10_q;
  logic            sg10_q;
  assign nw10 = -w9_q;
  assign aw10 = w9_q[31] ? nw10 : w9_q;
  always_ff @(posedge clk_i) begin
    hi10_q <= {32'b0, u9_q[MG_W-1:32]} * {21'b0, aw10};
    lo10_q <= {32'b0, u9_q[31:0]} * {32'b0, aw10};
    sg10_q <= un9_q ^ w9_q[31];
  end

  // Stage 11: combine, clamp a huge term and apply the sign.
  logic [56:0]               tm11, sum11;
  logic                      big11, sat11;
  logic signed [tps_pkg::TERM_W-1:0] val11_q;
  logic                      sat11_q;
  assign sum11 = {1'b0, hi10_q[39:0], 16'b0} + {9'b0, lo10_q[63:16]};
  assign big11 = |hi10_q[MG_W-1:40];
  always_comb begin
    sat11 = 1'b0;
    tm11  = sum11;
    if (big11 || (sum11 > TERM_LIM)) begin
      tm11  = TERM_LIM;
      sat11 = 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    val11_q <= sg10_q ? -$signed({1'b0, tm11}) : $signed({1'b0, tm11});
    sat11_q <= sat11;
  end

  assign term_o.vld   = vld_q[tps_pkg::PIPE_DEPTH-1];
  assign term_o.value = val11_q;
  assign term_o.sat   = sat11_q;

endmodule

[hw/rtl/thin_plate_spline_evaluator_top.sv]
// Top level of the thin plate spline evaluator: point ring, sequencer, sum.
//
// Channel   Direction  Handshake                 Payload
// item      in         start_i / busy_o          op_i, point_index_i, coord_x_i,
//                                                coord_y_i, weight_in_i
// result    out        result_valid_o (strobe)   height_o, saturated_o
// config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A load item leaves busy_o low.
// An evaluate item keeps busy_o high while the point ring turns once, the active
// points going one per cycle into the 11-stage term unit, which then drains.
// The result strobe is high in the first idle cycle, the one in which busy_o falls.
// Reset clears control state; the point ring holds no reset value.
// The receiver cannot stall; cfg_ready_o is always high.
`timescale 1ns / 1ps

module thin_plate_spline_evaluator_top #(
  parameter int unsigned NUM_POINTS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 op_i,
  input  logic [5:0]                           point_index_i,
  input  logic signed [tps_pkg::COORD_W-1:0]   coord_x_i,
  input  logic signed [tps_pkg::COORD_W-1:0]   coord_y_i,
  input  logic signed [tps_pkg::COORD_W-1:0]   weight_in_i,
  output logic                                 result_valid_o,
  output logic signed [tps_pkg::HEIGHT_W-1:0]  height_o,
  output logic                                 saturated_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tps_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [tps_pkg::COORD_W-1:0]          cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(NUM_POINTS);
  localparam int unsigned CMP_W = ((CNT_W > 7) ? CNT_W : 7) + 1;
  localparam int unsigned ACC_W = tps_pkg::TERM_W + $clog2(NUM_POINTS) + 2;
  localparam int unsigned AFF_W = 50;
  localparam int unsigned HW    = tps_pkg::HEIGHT_W;
  localparam logic signed [ACC_W-1:0] HI_LIM =
    {{(ACC_W-HW){1'b0}}, 1'b0, {(HW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] LO_LIM =
    {{(ACC_W-HW){1'b1}}, 1'b1, {(HW-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } tps_state_e;

  tps_state_e state_q, state_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [tps_pkg::DRAIN_W-1:0] drn_q, drn_d;
  logic                        accept, load_fire, eval_fire, shift_en, issue;

  // Configuration registers.
  logic [6:0]                  active_q;
  logic [tps_pkg::COORD_W-1:0] aff_c_q, aff_x_q, aff_z_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 7'd3;
      aff_c_q  <= '0;
      aff_x_q  <= '0;
      aff_z_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tps_pkg::REG_ACTIVE: active_q <= cfg_data_i[6:0];
        tps_pkg::REG_AFF_C:  aff_c_q  <= cfg_data_i;
        tps_pkg::REG_AFF_X:  aff_x_q  <= cfg_data_i;
        tps_pkg::REG_AFF_Z:  aff_z_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign accept    = start_i && !busy_o;
  assign load_fire = accept && (op_i == tps_pkg::OP_LOAD);
  assign eval_fire = accept && (op_i == tps_pkg::OP_EVAL);
  assign shift_en  = (state_q == ST_RUN);
  assign issue     = shift_en && (CMP_W'(cnt_q) < CMP_W'(active_q));

  // Query point, held for the whole evaluation.
  logic [tps_pkg::COORD_W-1:0] qx_q, qz_q;
  always_ff @(posedge clk_i) begin
    if (eval_fire) begin
      qx_q <= coord_x_i;
      qz_q <= coord_y_i;
    end
  end

  // Ring of point cells; cell 0 feeds the term unit.
  tps_pkg::point_t load_pt;
  tps_pkg::point_t ring [NUM_POINTS];
  assign load_pt.x = coord_x_i;
  assign load_pt.z = coord_y_i;
  assign load_pt.w = weight_in_i;

  for (genvar g = 0; g < NUM_POINTS; g++) begin : g_cell
    tps_cell u_cell (
      .clk_i     (clk_i),
      .load_i    (load_fire && (32'(point_index_i) == 32'(g))),
      .shift_i   (shift_en),
      .load_pt_i (load_pt),
      .next_pt_i (ring[(g + 1) % NUM_POINTS]),
      .pt_o      (ring[g])
    );
  end

  tps_pkg::term_t term;

  tps_term u_term (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .qx_i    (qx_q),
    .qz_i    (qz_q),
    .pt_i    (ring[0]),
    .term_o  (term)
  );

  // Affine part: two products, then their signed sum.
  logic [31:0] nax, naz, nqx, nqz, max, maz, mqx, mqz;
  logic [63:0] px_q, pz_q;
  logic        sx_q, sz_q;
  logic signed [AFF_W-1:0] ax_s, az_s, aff_q;
  assign nax = -aff_x_q;
  assign naz = -aff_z_q;
  assign nqx = -qx_q;
  assign nqz = -qz_q;
  assign max = aff_x_q[31] ? nax : aff_x_q;
  assign maz = aff_z_q[31] ? naz : aff_z_q;
  assign mqx = qx_q[31] ? nqx : qx_q;
  assign mqz = qz_q[31] ? nqz : qz_q;
  assign ax_s = sx_q ? -$signed({2'b0, px_q[63:16]}) : $signed({2'b0, px_q[63:16]});
  assign az_s = sz_q ? -$signed({2'b0, pz_q[63:16]}) : $signed({2'b0, pz_q[63:16]});
  always_ff @(posedge clk_i) begin
    px_q  <= {32'b0, max} * {32'b0, mqx};
    pz_q  <= {32'b0, maz} * {32'b0, mqz};
    sx_q  <= aff_x_q[31] ^ qx_q[31];
    sz_q  <= aff_z_q[31] ^ qz_q[31];
    aff_q <= ax_s + az_s;
  end

  // Accumulator of the affine part and all terms.
  logic signed [ACC_W-1:0] acc_q, acc_d, term_add, aff_add;
  logic                    sat_q, sat_d;
  assign term_add = term.vld ?
    {{(ACC_W-tps_pkg::TERM_W){term.value[tps_pkg::TERM_W-1]}}, term.value} : '0;
  assign aff_add = (shift_en && (cnt_q == CNT_W'(2))) ?
    {{(ACC_W-AFF_W){aff_q[AFF_W-1]}}, aff_q} : '0;

  always_comb begin
    acc_d = acc_q + term_add + aff_add;
    sat_d = sat_q | (term.vld & term.sat);
    if (eval_fire) begin
      acc_d = {{(ACC_W-32){aff_c_q[31]}}, aff_c_q};
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sat_q <= sat_d;
  end

  // Sequencer: one ring turn, pipeline drain, then the result.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    drn_d   = drn_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        drn_d = '0;
        if (eval_fire) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_q == CNT_W'(NUM_POINTS - 1)) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (drn_q == tps_pkg::DRAIN_W'(tps_pkg::PIPE_DEPTH - 1)) begin
          drn_d   = '0;
          state_d = ST_FIN;
        end else begin
          drn_d = drn_q + 1'b1;
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      drn_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drn_q   <= drn_d;
    end
  end

  // Result register with clipping to the height range.
  logic res_vld_q;
  logic signed [HW-1:0] height_q;
  logic sat_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= (state_q == ST_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN) begin
      if (acc_q > HI_LIM) begin
        height_q  <= HI_LIM[HW-1:0];
        sat_out_q <= 1'b1;
      end else if (acc_q < LO_LIM) begin
        height_q  <= LO_LIM[HW-1:0];
        sat_out_q <= 1'b1;
      end else begin
        height_q  <= acc_q[HW-1:0];
        sat_out_q <= sat_q;
      end
    end
  end

  assign result_valid_o = res_vld_q;
  assign height_o       = height_q;
  assign saturated_o    = sat_out_q;

  // The result strobe lasts a single cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // All terms have left the unit before the result is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> !term.vld)
    else $error("term still in flight at result time");

  // An accepted evaluate item makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_fire |=> busy_o)
    else $error("evaluate item did not start the sequencer");

  // The ring is aligned whenever the block is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q == '0))
    else $error("ring turn counter not at zero when idle");

endmodule

[sim/thin_plate_spline_evaluator_top_tb.sv]
// Self-checking testbench of the thin plate spline evaluator top level.
`timescale 1ns / 1ps

module thin_plate_spline_evaluator_top_tb;

  localparam int unsigned NPTS     = 64;
  localparam int unsigned SETTLE   = NPTS + 20;
  localparam longint      TERM_CAP = 64'sd1 <<< 56;
  localparam longint      H_MAX    = (64'sd1 <<< 47) - 1;
  localparam longint      H_MIN    = -(64'sd1 <<< 47);
  localparam longint      LN2_Q16  = 45426;
  localparam int          LN_FRAC [17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870,
                                           23783, 26573, 29248, 31818, 34292, 36675,
                                           38975, 41196, 43345, 45426};

  typedef struct {
    logic                               op;
    logic [5:0]                         idx;
    logic signed [tps_pkg::COORD_W-1:0] x;
    logic signed [tps_pkg::COORD_W-1:0] z;
    logic signed [tps_pkg::COORD_W-1:0] w;
  } tps_item_t;

  typedef struct {
    logic signed [tps_pkg::HEIGHT_W-1:0] height;
    logic                                sat;
  } height_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                start_i = 1'b0;
  logic                                busy_o;
  logic                                op_i = tps_pkg::OP_LOAD;
  logic [5:0]                          point_index_i = '0;
  logic signed [tps_pkg::COORD_W-1:0]  coord_x_i = '0;
  logic signed [tps_pkg::COORD_W-1:0]  coord_y_i = '0;
  logic signed [tps_pkg::COORD_W-1:0]  weight_in_i = '0;
  logic                                result_valid_o;
  logic signed [tps_pkg::HEIGHT_W-1:0] height_o;
  logic                                saturated_o;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [tps_pkg::CFG_IDX_W-1:0]       cfg_index_i = tps_pkg::REG_ACTIVE;
  logic [tps_pkg::COORD_W-1:0]         cfg_data_i = '0;

  thin_plate_spline_evaluator_top #(.NUM_POINTS(NPTS)) i_dut (.*);

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: point tables and register copies.
  longint      pt_x [NPTS];
  longint      pt_z [NPTS];
  longint      pt_w [NPTS];
  int unsigned act_pts = 3;
  longint      aff_c = 0, aff_x = 0, aff_z = 0;

  tps_item_t   pending_items[$];
  height_t     expected_heights[$];
  int unsigned err_cnt = 0, n_loads = 0, n_evals = 0, n_results = 0, n_sat = 0;
  bit          no_idle = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Radial basis value U(d2) in Q.16 as magnitude; neg follows the sign of ln(d2).
  function automatic logic [63:0] radial_q16(input longint dx, input longint dz,
                                             output bit neg);
    logic [64:0] ax, az, d2;
    logic [31:0] mant;
    logic [15:0] fr;
    int          p, k;
    longint      lm, ln, ln_mag;
    logic [63:0] mg;
    neg = 1'b0;
    ax = (dx < 0) ? -dx : dx;
    az = (dz < 0) ? -dz : dz;
    d2 = ax * ax + az * az;
    if (d2 == 0) return 64'd0;
    p = 0;
    for (int j = 0; j < 65; j++) if (d2[j]) p = j;
    if (p >= 31) mant = 32'(d2 >> (p - 31));
    else mant = 32'(d2 << (31 - p));
    fr = mant[30:15];
    k = fr[15:12];
    lm = LN_FRAC[k] + (((LN_FRAC[k+1] - LN_FRAC[k]) * longint'(fr[11:0])) >>> 12);
    ln = longint'(p - 32) * LN2_Q16 + lm;
    neg = (ln < 0);
    ln_mag = neg ? -ln : ln;
    mg = 64'(mant) * 64'(ln_mag);
    if (p == 0) return 64'd0;
    return mg >> (64 - p);
  endfunction

  // Affine part plus all clamped spline terms, clipped to Q32.16.
  function automatic height_t predict_height(input tps_item_t it);
    height_t     r;
    longint      qx, qz, sum, w;
    logic [63:0] u, aw, hi, tm, pm;
    bit          neg, sat;
    int unsigned n;
    qx = it.x;
    qz = it.z;
    sat = 1'b0;
    sum = aff_c;
    pm = (64'(aff_x < 0 ? -aff_x : aff_x) * 64'(qx < 0 ? -qx : qx)) >> 16;
    sum += ((aff_x < 0) != (qx < 0)) ? -longint'(pm) : longint'(pm);
    pm = (64'(aff_z < 0 ? -aff_z : aff_z) * 64'(qz < 0 ? -qz : qz)) >> 16;
    sum += ((aff_z < 0) != (qz < 0)) ? -longint'(pm) : longint'(pm);
    n = (act_pts < NPTS) ? act_pts : NPTS;
    for (int i = 0; i < n; i++) begin
      u = radial_q16(qx - pt_x[i], qz - pt_z[i], neg);
      w = pt_w[i];
      aw = (w < 0) ? -w : w;
      hi = (u >> 32) * aw;
      if (hi >= (64'd1 << 40)) begin
        tm = TERM_CAP;
        sat = 1'b1;
      end else begin
        tm = (hi << 16) + (((u & 64'hFFFF_FFFF) * aw) >> 16);
        if (tm > TERM_CAP) begin
          tm = TERM_CAP;
          sat = 1'b1;
        end
      end
      sum += (neg != (w < 0)) ? -longint'(tm) : longint'(tm);
    end
    if (sum > H_MAX) begin
      sum = H_MAX;
      sat = 1'b1;
    end
    if (sum < H_MIN) begin
      sum = H_MIN;
      sat = 1'b1;
    end
    r.height = sum[tps_pkg::HEIGHT_W-1:0];
    r.sat = sat;
    return r;
  endfunction

  // Driver: presents pending items, predicts each accepted one, idles at random.
  tps_item_t   cur;
  int unsigned wait_cnt = 0;

  task automatic present_next();
    cur = pending_items.pop_front();
    start_i       <= 1'b1;
    op_i          <= cur.op;
    point_index_i <= cur.idx;
    coord_x_i     <= cur.x;
    coord_y_i     <= cur.z;
    weight_in_i   <= cur.w;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && !busy_o) begin
      if (cur.op == tps_pkg::OP_LOAD) begin
        pt_x[cur.idx] = cur.x;
        pt_z[cur.idx] = cur.z;
        pt_w[cur.idx] = cur.w;
        n_loads++;
      end else begin
        expected_heights.push_back(predict_height(cur));
        n_evals++;
      end
      wait_cnt = no_idle ? 0 : $urandom_range(0, 18);
      if (wait_cnt == 0 && pending_items.size() != 0) present_next();
      else start_i <= 1'b0;
    end else if (!start_i) begin
      if (wait_cnt > 0) wait_cnt--;
      else if (pending_items.size() != 0) present_next();
    end
  end

  // Monitor: compares each result strobe with the oldest expected height.
  always @(posedge clk_i) begin
    height_t e;
    if (rst_ni && result_valid_o) begin
      n_results++;
      if (saturated_o) n_sat++;
      if (expected_heights.size() == 0) begin
        report_mismatch($sformatf("unexpected result height=%0d", height_o));
      end else begin
        e = expected_heights.pop_front();
        if (height_o !== e.height)
          report_mismatch($sformatf("height got %0d want %0d", height_o, e.height));
        if (saturated_o !== e.sat)
          report_mismatch($sformatf("saturated got %0b want %0b", saturated_o, e.sat));
      end
    end
  end

  // Stimulus side shadow of what has been loaded.
  bit     written [NPTS];
  longint gen_x [NPTS];
  longint gen_z [NPTS];

  task automatic push_load(input int idx, input longint x, input longint z, input longint w);
    tps_item_t it;
    it.op = tps_pkg::OP_LOAD;
    it.idx = 6'(idx);
    it.x = 32'(x);
    it.z = 32'(z);
    it.w = 32'(w);
    written[idx] = 1'b1;
    gen_x[idx] = it.x;
    gen_z[idx] = it.z;
    pending_items.push_back(it);
  endtask

  task automatic push_eval(input longint x, input longint z);
    tps_item_t it;
    it.op = tps_pkg::OP_EVAL;
    it.idx = 6'($urandom);
    it.x = 32'(x);
    it.z = 32'(z);
    it.w = 32'($urandom);
    pending_items.push_back(it);
  endtask

  // Coordinate drawn from full range, near a point, on a point, at the extremes or scaled down.
  function automatic longint rand_coord(input int j, input bit is_z);
    longint base;
    base = is_z ? gen_z[j] : gen_x[j];
    case ($urandom_range(0, 5))
      0:       return longint'(int'($urandom));
      1:       return base;
      2:       return base + $urandom_range(0, 255) - 128;
      3:       return base + $urandom_range(0, 2 ** 21) - 2 ** 20;
      4:       return $urandom_range(0, 1) ? -(64'sd1 <<< 31) : (64'sd1 <<< 31) - 1;
      default: return longint'(int'($urandom)) >>> $urandom_range(0, 24);
    endcase
  endfunction

  function automatic longint rand_weight();
    case ($urandom_range(0, 3))
      0:       return longint'(int'($urandom));
      1:       return longint'(int'($urandom)) >>> 16;
      2:       return $urandom_range(0, 1) ? -(64'sd1 <<< 31) : (64'sd1 <<< 31) - 1;
      default: return longint'(int'($urandom)) >>> $urandom_range(0, 30);
    endcase
  endfunction

  // Waits until no item is pending and every expected height has come.
  task automatic wait_drained();
    while (pending_items.size() != 0 || start_i || expected_heights.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tps_pkg::COORD_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      tps_pkg::REG_ACTIVE: act_pts = data[6:0];
      tps_pkg::REG_AFF_C:  aff_c = longint'(signed'(data));
      tps_pkg::REG_AFF_X:  aff_x = longint'(signed'(data));
      default:             aff_z = longint'(signed'(data));
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // One phase: new settings, loads for unwritten active entries, random items.
  task automatic run_phase(input int unsigned act, input logic [31:0] c,
                           input logic [31:0] ax, input logic [31:0] az,
                           input int unsigned n_items);
    int unsigned eff;
    int          j;
    wait_drained();
    write_reg(tps_pkg::REG_ACTIVE, act);
    write_reg(tps_pkg::REG_AFF_C, c);
    write_reg(tps_pkg::REG_AFF_X, ax);
    write_reg(tps_pkg::REG_AFF_Z, az);
    eff = (act < NPTS) ? act : NPTS;
    for (int i = 0; i < eff; i++)
      if (!written[i])
        push_load(i, longint'(int'($urandom)) >>> $urandom_range(0, 16),
                  longint'(int'($urandom)) >>> $urandom_range(0, 16), rand_weight());
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n_items; i++) begin
      j = $urandom_range(0, (eff > 0) ? eff - 1 : NPTS - 1);
      if ($urandom_range(0, 9) < 4)
        push_load($urandom_range(0, NPTS - 1), rand_coord(j, 1'b0), rand_coord(j, 1'b1),
                  rand_weight());
      else
        push_eval(rand_coord(j, 1'b0), rand_coord(j, 1'b1));
    end
  endtask

  // Main sequence: reset, directed items, then phases through the settings.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: extreme points and weights, zero distance, widest distance,
    // tiny distances with negative log, huge terms and clipped sums.
    push_load(0, -(64'sd1 <<< 31), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
    push_load(1, (64'sd1 <<< 31) - 1, 0, -(64'sd1 <<< 31));
    push_load(2, 0, (64'sd1 <<< 31) - 1, 65536);
    push_eval(-(64'sd1 <<< 31), -(64'sd1 <<< 31));
    push_eval((64'sd1 <<< 31) - 1, (64'sd1 <<< 31) - 1);
    push_eval(0, 0);
    push_eval(1, (64'sd1 <<< 31) - 1);
    push_eval((64'sd1 <<< 31) - 2, 1);
    push_eval(-(64'sd1 <<< 31) + 1, -(64'sd1 <<< 31));
    push_load(2, 0, 0, 0);
    push_eval(0, 0);
    push_eval(256, -256);
    push_load(63, 5, 5, 1);
    run_phase(3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 12);
    run_phase(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 60);
    run_phase(1, $urandom, $urandom, $urandom, 100);
    run_phase(2, 0, 0, 0, 100);
    run_phase(64, $urandom, $urandom, $urandom, 120);
    run_phase(127, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 120);
    run_phase($urandom_range(3, 64), $urandom, $urandom, $urandom, 130);
    run_phase($urandom_range(3, 16), $urandom, 0, $urandom, 130);
    run_phase($urandom_range(3, 64), $urandom, $urandom, $urandom, 130);
    wait_drained();
    if (expected_heights.size() != 0)
      report_mismatch($sformatf("%0d expected results never came", expected_heights.size()));
    $display("Covered %0d loads and %0d evaluations; %0d results, %0d saturated.",
             n_loads, n_evals, n_results, n_sat);
    $display("Settings spanned active counts 0 to 127 and extreme affine coefficients.");
    if (err_cnt == 0) begin
      $display("** thin_plate_spline_evaluator_top: PASSED **");
    end else begin
      $display("** thin_plate_spline_evaluator_top: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #8_000_000;
    $display("Timeout with %0d items pending.", pending_items.size());
    $display("** thin_plate_spline_evaluator_top: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/tps_pkg.sv
hw/rtl/tps_cell.sv
hw/rtl/tps_term.sv
hw/rtl/thin_plate_spline_evaluator_top.sv
sim/thin_plate_spline_evaluator_top_tb.sv
